FILE: hdl/rau_pkg.sv
// rau_pkg: shared word width, command codes and the control/status structs
// between the top level and the reduction unit.
// No dependencies.
package rau_pkg;

	// fraction part width
	localparam int W  = 32;
	// width of a bit position / step counter over one word
	localparam int KW = $clog2(W);

	// command codes
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_RED = 3'd4
	} cmd_t;

	// request into the reduction unit
	typedef struct packed {
		logic         start;
		logic [W-1:0] a_num;
		logic [W-1:0] a_den;
	} red_ctl_t;

	// answer from the reduction unit
	typedef struct packed {
		logic         done;
		logic         error;
		logic [W-1:0] num;
		logic [W-1:0] den;
	} red_stat_t;

endpackage

FILE: hdl/rau_reduce.sv
// rau_reduce: reduces a fraction by the gcd of its part magnitudes, using one
// shared subtractor for a binary gcd and then two restoring divisions.
// Depends on rau_pkg.
module rau_reduce (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rau_pkg::red_ctl_t    ctl,
	output rau_pkg::red_stat_t   stat
);
	import rau_pkg::*;

	typedef enum logic [4:0] {
		R_IDLE = 5'b00001,
		R_GCD  = 5'b00010,
		R_DIVN = 5'b00100,
		R_DIVD = 5'b01000,
		R_DONE = 5'b10000
	} red_state_t;

	red_state_t state_q;

	logic [W-1:0]  x_q, y_q, g_q, rem_q, dvd_q, mag_n_q, mag_d_q;
	logic [W-1:0]  num_q, den_q;
	logic [KW-1:0] k_q, cnt_q;
	logic          neg_n_q, neg_d_q, err_q;

	logic [W-1:0]  mag_n, mag_d;
	logic          x_gt;
	logic [W:0]    sub_a, sub_b;
	logic [W+1:0]  diff;
	logic          borrow;
	logic [W-1:0]  rem_next, quo_next;

	// magnitudes of the incoming parts
	assign mag_n = ctl.a_num[W-1] ? (~ctl.a_num + W'(1)) : ctl.a_num;
	assign mag_d = ctl.a_den[W-1] ? (~ctl.a_den + W'(1)) : ctl.a_den;

	// shared subtractor: max minus min in the gcd, trial subtract when dividing
	assign x_gt = x_q > y_q;
	always_comb begin
		if (state_q == R_GCD) begin
			sub_a = {1'b0, (x_gt ? x_q : y_q)};
			sub_b = {1'b0, (x_gt ? y_q : x_q)};
		end else begin
			sub_a = {rem_q, dvd_q[W-1]};
			sub_b = {1'b0, g_q};
		end
	end
	assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow   = diff[W+1];
	assign rem_next = borrow ? sub_a[W-1:0] : diff[W-1:0];
	assign quo_next = {dvd_q[W-2:0], ~borrow};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (ctl.start) begin
						if (mag_n == '0 && mag_d == '0)
							state_q <= R_DONE;
						else if (mag_n == '0 || mag_d == '0)
							state_q <= R_DIVN;
						else
							state_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (x_q[0] && y_q[0] && x_q == y_q)
						state_q <= R_DIVN;
				end
				R_DIVN: begin
					if (cnt_q == '0)
						state_q <= R_DIVD;
				end
				R_DIVD: begin
					if (cnt_q == '0)
						state_q <= R_DONE;
				end
				R_DONE:  state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (ctl.start) begin
					x_q     <= mag_n;
					y_q     <= mag_d;
					mag_n_q <= mag_n;
					mag_d_q <= mag_d;
					neg_n_q <= ctl.a_num[W-1];
					neg_d_q <= ctl.a_den[W-1];
					k_q     <= '0;
					rem_q   <= '0;
					dvd_q   <= mag_n;
					cnt_q   <= KW'(W-1);
					err_q   <= 1'b0;
					// zero parts: the gcd is the other magnitude, or undefined
					if (mag_n == '0 && mag_d == '0) begin
						err_q <= 1'b1;
						num_q <= ctl.a_num;
						den_q <= ctl.a_den;
					end else if (mag_n == '0) begin
						g_q <= mag_d;
					end else begin
						g_q <= mag_n;
					end
				end
			end
			R_GCD: begin
				// one binary gcd step
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + KW'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q == y_q) begin
					g_q   <= x_q << k_q;
					rem_q <= '0;
					dvd_q <= mag_n_q;
					cnt_q <= KW'(W-1);
				end else if (x_gt) begin
					x_q <= diff[W:1];
				end else begin
					y_q <= diff[W:1];
				end
			end
			R_DIVN: begin
				// one quotient bit of the numerator
				rem_q <= rem_next;
				dvd_q <= quo_next;
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == '0) begin
					num_q <= neg_n_q ? (~quo_next + W'(1)) : quo_next;
					rem_q <= '0;
					dvd_q <= mag_d_q;
					cnt_q <= KW'(W-1);
				end
			end
			R_DIVD: begin
				// one quotient bit of the denominator
				rem_q <= rem_next;
				dvd_q <= quo_next;
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == '0)
					den_q <= neg_d_q ? (~quo_next + W'(1)) : quo_next;
			end
			default: begin
			end
		endcase
	end

	assign stat.done  = (state_q == R_DONE);
	assign stat.error = err_q;
	assign stat.num   = num_q;
	assign stat.den   = den_q;

endmodule

FILE: hdl/rational_arith_unit.sv
// rational_arith_unit: fraction add, subtract, multiply, divide and reduce.
// Depends on rau_pkg and rau_reduce.
//
// A transaction is taken when start is high and busy is low; for arithmetic
// and reduce commands busy then stays high until the result is shown. The
// result on res_num, res_den and error is flagged by done for exactly one
// cycle and cannot be held off, so capture it on that cycle. Add and subtract
// step through S_M0 to S_M3, multiply and divide through S_M0 to S_M2, both
// paced by the single shared 32x32 multiplier used once per cross product.
// Unused command codes pass a_num/a_den back in the cycle after they are
// taken, with busy low. Reduce runs a binary gcd on the shared subtractor
// (one step per cycle, the number of steps set by the operand bits), then
// two restoring divisions by the gcd; one zero part skips it, two flag error.
// A new transaction may be started in the cycle that done is high.
module rational_arith_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             command,
	input  logic [rau_pkg::W-1:0]  a_num,
	input  logic [rau_pkg::W-1:0]  a_den,
	input  logic [rau_pkg::W-1:0]  b_num,
	input  logic [rau_pkg::W-1:0]  b_den,
	output logic                   done,
	output logic [rau_pkg::W-1:0]  res_num,
	output logic [rau_pkg::W-1:0]  res_den,
	output logic                   error
);
	import rau_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_M0   = 6'b000010,
		S_M1   = 6'b000100,
		S_M2   = 6'b001000,
		S_M3   = 6'b010000,
		S_RED  = 6'b100000
	} state_t;

	state_t       state_q;
	logic         done_q, red_start_q;
	cmd_t         cmd_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q, prod_q;
	logic [W-1:0] res_num_q, res_den_q;
	logic         error_q;

	cmd_t         cmd_in;
	logic         accept, in_arith, in_red, two_terms;
	logic [W-1:0] mul_x, mul_y, prod, sum;
	red_ctl_t     red_ctl;
	red_stat_t    red_stat;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cmd_in = cmd_t'(command);

	// decode of the incoming command
	always_comb begin
		in_arith = 1'b0;
		in_red   = 1'b0;
		case (cmd_in) inside
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: in_arith = 1'b1;
			CMD_RED:                            in_red   = 1'b1;
			default: begin
			end
		endcase
	end

	// add and subtract need a third cross product
	assign two_terms = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			S_M0: begin
				mul_x = an_q;
				mul_y = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			S_M1: begin
				if (two_terms) begin
					mul_x = bn_q;
					mul_y = ad_q;
				end else begin
					mul_x = ad_q;
					mul_y = (cmd_q == CMD_DIV) ? bn_q : bd_q;
				end
			end
			default: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
		endcase
	end

	// low word of the product is the same signed or unsigned
	assign prod = mul_x * mul_y;
	assign sum  = (cmd_q == CMD_SUB) ? (res_num_q - prod_q) : (res_num_q + prod_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			red_start_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			red_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_arith) begin
							state_q <= S_M0;
						end else if (in_red) begin
							state_q     <= S_RED;
							red_start_q <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: begin
					if (two_terms) begin
						state_q <= S_M3;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_M3: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RED: begin
					if (red_stat.done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand capture and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd_in;
					an_q  <= a_num;
					ad_q  <= a_den;
					bn_q  <= b_num;
					bd_q  <= b_den;
					if (!in_arith && !in_red) begin
						res_num_q <= a_num;
						res_den_q <= a_den;
						error_q   <= 1'b0;
					end
				end
			end
			S_M0: prod_q <= prod;
			S_M1: begin
				res_num_q <= prod_q;
				prod_q    <= prod;
			end
			S_M2: begin
				if (two_terms) begin
					res_num_q <= sum;
					prod_q    <= prod;
				end else begin
					res_den_q <= prod_q;
					error_q   <= 1'b0;
				end
			end
			S_M3: begin
				res_den_q <= prod_q;
				error_q   <= 1'b0;
			end
			S_RED: begin
				if (red_stat.done) begin
					res_num_q <= red_stat.num;
					res_den_q <= red_stat.den;
					error_q   <= red_stat.error;
				end
			end
			default: begin
			end
		endcase
	end

	// gcd reduction unit
	assign red_ctl.start = red_start_q;
	assign red_ctl.a_num = an_q;
	assign red_ctl.a_den = ad_q;

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (red_ctl),
		.stat   (red_stat)
	);

	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign error   = error_q;

endmodule

FILE: tb/rational_arith_unit_tb.sv
// rational_arith_unit_tb: self-checking bench for the fraction arithmetic unit.
// Drives add/subtract/multiply/divide/reduce and unused-code transactions, predicts each result
// in-bench and compares it with the done-strobed output. Depends on rau_pkg, rational_arith_unit.
`timescale 1ns / 100ps

module rational_arith_unit_tb;
	import rau_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 120;
	localparam int SETTLE_CYCLES = 200;

	// one fraction transaction and the answer it should give
	typedef struct {
		logic [2:0]   cmd;
		logic [W-1:0] an;
		logic [W-1:0] ad;
		logic [W-1:0] bn;
		logic [W-1:0] bd;
	} frac_in_t;

	typedef struct {
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic         err;
	} frac_out_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	logic [2:0]   command = '0;
	logic [W-1:0] a_num = '0;
	logic [W-1:0] a_den = '0;
	logic [W-1:0] b_num = '0;
	logic [W-1:0] b_den = '0;
	logic         done;
	logic [W-1:0] res_num;
	logic [W-1:0] res_den;
	logic         error;

	frac_in_t  fraction_q[$];
	frac_out_t answer_q[$];
	frac_in_t  on_bus;
	int        idle_pct = 0;
	int        fail_cnt = 0;
	int        cycle_cnt = 0;

	rational_arith_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.done    (done),
		.res_num (res_num),
		.res_den (res_den),
		.error   (error)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// expected answer: cross products wrap to the word, reduce divides by the gcd
	function automatic frac_out_t fraction_result(frac_in_t t);
		frac_out_t    r;
		logic [W-1:0] mag_n, mag_d, x, y, rem, q;
		r.num = t.an;
		r.den = t.ad;
		r.err = 1'b0;
		case (t.cmd)
			CMD_ADD: begin
				r.num = t.an * t.bd + t.bn * t.ad;
				r.den = t.ad * t.bd;
			end
			CMD_SUB: begin
				r.num = t.an * t.bd - t.bn * t.ad;
				r.den = t.ad * t.bd;
			end
			CMD_MUL: begin
				r.num = t.an * t.bn;
				r.den = t.ad * t.bd;
			end
			CMD_DIV: begin
				r.num = t.an * t.bd;
				r.den = t.ad * t.bn;
			end
			CMD_RED: begin
				// magnitudes fit unsigned, the most negative value included
				mag_n = t.an[W-1] ? -t.an : t.an;
				mag_d = t.ad[W-1] ? -t.ad : t.ad;
				x = mag_n;
				y = mag_d;
				while (y != '0) begin
					rem = x % y;
					x = y;
					y = rem;
				end
				if (x == '0) begin
					r.err = 1'b1;
				end else begin
					q = mag_n / x;
					r.num = t.an[W-1] ? -q : q;
					q = mag_d / x;
					r.den = t.ad[W-1] ? -q : q;
				end
			end
			default: begin
				// unused codes pass the first fraction through
			end
		endcase
		return r;
	endfunction

	// operand word: zero, small signed, extremes, powers of two or anything
	function automatic logic [W-1:0] random_word();
		logic [W-1:0] v;
		case ($urandom_range(5))
			0: v = '0;
			1: v = $urandom_range(200) - 100;
			2: begin
				case ($urandom_range(4))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0001;
					2: v = 32'h8000_0000;
					3: v = 32'h0000_0001;
					default: v = 32'hffff_ffff;
				endcase
			end
			3: begin
				v = 32'd1 << $urandom_range(W - 1);
				if ($urandom_range(1) == 0)
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// random transaction, reduce mostly built with a shared factor
	function automatic frac_in_t random_fraction();
		frac_in_t    t;
		int unsigned pick, g;
		int          x, y;
		t.an = random_word();
		t.ad = random_word();
		t.bn = random_word();
		t.bd = random_word();
		pick = $urandom_range(99);
		if (pick < 68) begin
			t.cmd = 3'(pick / 17);
		end else if (pick < 95) begin
			t.cmd = CMD_RED;
			if ($urandom_range(3) != 0) begin
				g = ($urandom_range(1) == 0) ? (32'd1 << $urandom_range(12))
					: $urandom_range(5000, 1);
				x = int'($urandom_range(2000)) - 1000;
				y = int'($urandom_range(2000)) - 1000;
				t.an = x * g;
				t.ad = y * g;
			end
		end else begin
			t.cmd = 3'($urandom_range(7, 5));
		end
		return t;
	endfunction

	task automatic queue_item(logic [2:0] cmd, logic [W-1:0] an, logic [W-1:0] ad,
			logic [W-1:0] bn, logic [W-1:0] bd);
		frac_in_t t;
		t.cmd = cmd;
		t.an = an;
		t.ad = ad;
		t.bn = bn;
		t.bd = bd;
		fraction_q.push_back(t);
	endtask

	// block until every queued transaction is taken and answered
	task automatic wait_drained();
		while (fraction_q.size() != 0 || start || answer_q.size() != 0)
			@(negedge clk);
	endtask

	// driver: hold start until taken, then maybe idle before the next one
	always @(posedge clk) begin : drv
		logic go;
		go = 1'b0;
		if (arst_n) begin
			if (start && !busy)
				answer_q.push_back(fraction_result(on_bus));
			if (!(start && busy)) begin
				go = fraction_q.size() != 0 && $urandom_range(99) >= idle_pct;
				if (go) begin
					on_bus = fraction_q.pop_front();
					command <= on_bus.cmd;
					a_num <= on_bus.an;
					a_den <= on_bus.ad;
					b_num <= on_bus.bn;
					b_den <= on_bus.bd;
				end
				start <= go;
			end
		end
	end

	// monitor: every done strobe must match the oldest expectation
	always @(posedge clk) begin : mon
		frac_out_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$error("unexpected result: res_num %h res_den %h error %b",
					res_num, res_den, error);
				fail_cnt++;
			end else begin
				want = answer_q.pop_front();
				if (res_num !== want.num) begin
					$error("res_num: expected %h, got %h", want.num, res_num);
					fail_cnt++;
				end
				if (res_den !== want.den) begin
					$error("res_den: expected %h, got %h", want.den, res_den);
					fail_cnt++;
				end
				if (error !== want.err) begin
					$error("error: expected %b, got %b", want.err, error);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("rational_arith_unit_tb NOT OK");
			$finish;
		end
	end

	// stimulus: reset, directed corners, then random phases with varied idling
	initial begin : stim
		int phase_idle[5];
		phase_idle = '{0, 46, 6, 46, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// plain arithmetic and wrap-around
		queue_item(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		queue_item(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
		queue_item(CMD_MUL, -32'sd3, 32'd4, 32'd5, -32'sd7);
		queue_item(CMD_DIV, 32'd3, 32'd4, 32'd5, 32'd7);
		queue_item(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0001);
		queue_item(CMD_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
		queue_item(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		queue_item(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		// zero denominators and a zero divisor give no error
		queue_item(CMD_ADD, 32'd5, 32'd0, 32'd7, 32'd0);
		queue_item(CMD_DIV, 32'd5, 32'd3, 32'd0, 32'd2);
		// reduce, plain and signed
		queue_item(CMD_RED, 32'd6, 32'd4, 32'hffff_ffff, 32'hffff_ffff);
		queue_item(CMD_RED, -32'sd6, 32'd4, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'd1000, -32'sd250, 32'd0, 32'd0);
		// reduce with one part zero
		queue_item(CMD_RED, 32'd0, 32'd5, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'd0, -32'sd5, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'd7, 32'd0, 32'd0, 32'd0);
		queue_item(CMD_RED, -32'sd7, 32'd0, 32'd0, 32'd0);
		// reduce of zero over zero flags an error
		queue_item(CMD_RED, 32'd0, 32'd0, 32'h1234_5678, 32'h9abc_def0);
		// most negative value under reduce
		queue_item(CMD_RED, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
		queue_item(CMD_RED, 32'h7fff_ffff, 32'h8000_0001, 32'd0, 32'd0);
		// unused command codes
		queue_item(3'd5, 32'h1234_5678, 32'h8765_4321, 32'd1, 32'd1);
		queue_item(3'd6, 32'hffff_ffff, 32'd0, 32'd2, 32'd2);
		queue_item(3'd7, 32'd0, 32'h8000_0000, 32'd3, 32'd3);
		wait_drained();

		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			repeat (PHASE_ITEMS)
				fraction_q.push_back(random_fraction());
			wait_drained();
		end

		// let any stray strobe show up before the verdict
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_cnt == 0)
			$display("rational_arith_unit_tb OK");
		else
			$display("rational_arith_unit_tb NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
hdl/rau_pkg.sv
hdl/rau_reduce.sv
hdl/rational_arith_unit.sv
tb/rational_arith_unit_tb.sv
